>>> hw/rtl/assert_macros.svh
// Assertion macros shared by the trochoid point generator RTL.
// Depends on nothing; synthesis builds define SYNTHESIS and get empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// check that a property holds at every clock edge outside reset
`define TPG_ASSERT(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
		else $error("assertion failed");
// check that an expression is never true outside reset
`define TPG_NEVER(lbl, clk, rstn, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
		else $error("forbidden condition");
`else
`define TPG_ASSERT(lbl, clk, rstn, prop)
`define TPG_NEVER(lbl, clk, rstn, expr)
`endif
`endif

>>> hw/rtl/tpg_pkg.sv
// Shared types and constants of the trochoid point generator.
// Used by the controller, the datapath and the top level.
`default_nettype none
package tpg_pkg;

	localparam int unsigned N_W        = 16;
	localparam int unsigned RAD_W      = 14;
	localparam int unsigned STEP_W     = 31;
	localparam int unsigned PHASE_W    = 32;
	localparam int unsigned COORD_W    = 16;
	localparam int unsigned DIV_W      = 48;
	localparam int unsigned DIV_DIGIT  = 6;
	localparam int unsigned COORD_LIMIT = 30720;
	localparam logic [PHASE_W-1:0] QUARTER_TURN = 32'h4000_0000;
	localparam logic [3:0] LAST_STEP = 4'd8;
	localparam logic [3:0] ROM_STEPS = 4'd4;

	typedef enum logic [1:0] {TERM_CA, TERM_SA, TERM_CB, TERM_SB} term_t;
	typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_FINISH} state_t;
	typedef enum logic [2:0] {
		REG_CURVE_MODE, REG_BIG_RADIUS, REG_SMALL_RADIUS, REG_PEN_DISTANCE, REG_PHASE_STEP
	} reg_idx_t;

	typedef struct packed {
		logic  start;
		logic  rom_en;
		term_t rom_term;
		logic  div_load;
		logic  div_en;
		logic  finish;
	} tpg_cmd_t;

	typedef struct packed {
		logic out_blocked;
	} tpg_status_t;

endpackage
`default_nettype wire

>>> hw/rtl/tpg_sine_rom.sv
// Sine ROM with registered read; contents are built at elaboration.
// Depends on nothing outside this file.
`default_nettype none
module tpg_sine_rom #(
	parameter int unsigned DEPTH = 1024,
	parameter int unsigned BITS  = 16
) (
	input  wire logic                     clk,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic signed [BITS-1:0]        rd_data
);
	localparam int unsigned ADDR_W = $clog2(DEPTH);
	localparam longint unsigned Q30_ONE = 64'd1073741824;
	localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

	typedef logic signed [BITS-1:0] rom_arr_t [DEPTH];

	// quarter-wave folded Taylor sine of each entry's phase
	function automatic rom_arr_t build_rom();
		rom_arr_t arr;
		longint unsigned t, quad, f, x, x2, h, s, amp, v;
		amp = (64'd1 << (BITS - 1)) - 64'd1;
		for (int q = 0; q < int'(DEPTH); q++) begin
			t = (longint'(q) << (32 - ADDR_W)) & 64'hFFFF_FFFF;
			quad = t >> 30;
			f = t & 64'h3FFF_FFFF;
			if (quad[0]) f = Q30_ONE - f;
			x = (f * HALF_PI_Q30) >> 30;
			x2 = (x * x) >> 30;
			h = Q30_ONE - x2 / 110;
			h = Q30_ONE - ((x2 * h) >> 30) / 72;
			h = Q30_ONE - ((x2 * h) >> 30) / 42;
			h = Q30_ONE - ((x2 * h) >> 30) / 20;
			h = Q30_ONE - ((x2 * h) >> 30) / 6;
			s = (x * h) >> 30;
			v = (s * amp + (Q30_ONE >> 1)) >> 30;
			if (quad[1]) arr[q] = BITS'(-v);
			else arr[q] = BITS'(v);
		end
		return arr;
	endfunction

	localparam rom_arr_t SINE = build_rom();

	// read one entry a cycle while rd_en is high
	always_ff @(posedge clk) begin
		if (rd_en) rd_data <= SINE[rd_addr];
	end
endmodule
`default_nettype wire

>>> hw/rtl/tpg_ctrl.sv
// Sequencer of the trochoid point generator: handshake and step schedule.
// Depends on tpg_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module tpg_ctrl
	import tpg_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire tpg_status_t status,
	output tpg_cmd_t         cmd
);
	state_t state_q, state_d;
	logic [3:0] cnt_q;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:   if (in_valid) state_d = ST_RUN;
			ST_RUN:    if (cnt_q == LAST_STEP) state_d = ST_FINISH;
			ST_FINISH: if (!status.out_blocked) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// commands
	always_comb begin
		cmd = '0;
		cmd.rom_term = term_t'(cnt_q[1:0]);
		in_stall = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				cmd.start = in_valid;
			end
			ST_RUN: begin
				cmd.rom_en = cnt_q < ROM_STEPS;
				cmd.div_load = cnt_q == 4'd0;
				cmd.div_en = cnt_q != 4'd0;
			end
			ST_FINISH: cmd.finish = !status.out_blocked;
			default: cmd = '0;
		endcase
	end

	// hold state and advance step count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_RUN) cnt_q <= cnt_q + 4'd1;
			else cnt_q <= '0;
		end
	end

	`TPG_NEVER(a_cnt_range, clk, arst_n, state_q == ST_RUN && cnt_q > LAST_STEP)
	`TPG_ASSERT(a_busy_after_accept, clk, arst_n, in_valid && !in_stall |=> in_stall)
	`TPG_NEVER(a_finish_when_blocked, clk, arst_n, cmd.finish && status.out_blocked)
endmodule
`default_nettype wire

>>> hw/rtl/tpg_datapath.sv
// Datapath: phases, sine lookups, shared multiplier, radix-64 divider, output register.
// Depends on tpg_pkg, tpg_sine_rom and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module tpg_datapath
	import tpg_pkg::*;
#(
	parameter int unsigned SINE_TABLE_DEPTH = 1024,
	parameter int unsigned SINE_BITS = 16
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire tpg_cmd_t            cmd,
	output tpg_status_t              status,
	input  wire logic                step_enable,
	input  wire logic                curve_mode,
	input  wire logic [RAD_W-1:0]    big_radius,
	input  wire logic [RAD_W-1:0]    small_radius,
	input  wire logic [RAD_W-1:0]    pen_distance,
	input  wire logic [STEP_W-1:0]   phase_step,
	output logic                     out_valid,
	input  wire logic                out_stall,
	output logic signed [COORD_W-1:0] x_position,
	output logic signed [COORD_W-1:0] y_position,
	output logic                     degenerate
);
	localparam int unsigned ADDR_W = $clog2(SINE_TABLE_DEPTH);
	localparam int unsigned PROD_W = N_W + SINE_BITS;
	localparam int unsigned ACC_W = PROD_W + 1;
	localparam int unsigned SH = SINE_BITS - 1;
	localparam logic signed [ACC_W:0] RND = {{(ACC_W + 1 - SH){1'b0}}, 1'b1, {(SH - 1){1'b0}}};
	localparam logic signed [ACC_W:0] LIM_HI = (ACC_W + 1)'(COORD_LIMIT);
	localparam logic signed [ACC_W:0] LIM_LO = -LIM_HI;

	logic [PHASE_W-1:0] primary_q, secondary_q;
	logic signed [N_W-1:0] n_q;
	logic step_en_q;
	logic signed [ACC_W-1:0] acc_x_q, acc_y_q;
	logic [DIV_W-1:0] quo_q;
	logic [RAD_W-1:0] rem_q;
	logic out_valid_q;

	// round half up to Q8.8 and saturate
	function automatic logic [COORD_W-1:0] to_coord(input logic signed [ACC_W-1:0] acc);
		logic signed [ACC_W:0] s, q;
		s = {acc[ACC_W-1], acc} + RND;
		q = s >>> SH;
		if (q > LIM_HI) q = LIM_HI;
		if (q < LIM_LO) q = LIM_LO;
		return q[COORD_W-1:0];
	endfunction

	// latch the item and the signed radius sum (difference in hypotrochoid mode)
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			step_en_q <= step_enable;
			if (curve_mode) n_q <= {2'b00, big_radius} - {2'b00, small_radius};
			else n_q <= {2'b00, big_radius} + {2'b00, small_radius};
		end
	end

	// select the lookup phase: cosine is the sine a quarter turn on
	logic [PHASE_W-1:0] ph_src, ph_sel;
	logic signed [SINE_BITS-1:0] sine_s1;
	always_comb begin
		if (cmd.rom_term == TERM_CA || cmd.rom_term == TERM_SA) ph_src = primary_q;
		else ph_src = secondary_q;
		if (cmd.rom_term == TERM_CA || cmd.rom_term == TERM_CB) ph_sel = ph_src + QUARTER_TURN;
		else ph_sel = ph_src;
	end

	tpg_sine_rom #(.DEPTH(SINE_TABLE_DEPTH), .BITS(SINE_BITS)) u_rom (
		.clk     (clk),
		.rd_en   (cmd.rom_en),
		.rd_addr (ph_sel[PHASE_W-1 -: ADDR_W]),
		.rd_data (sine_s1)
	);

	// tag the lookup and product stages
	term_t term_s1, term_s2;
	logic vld_s1, vld_s2;
	logic signed [PROD_W-1:0] prod_s2;
	logic signed [N_W-1:0] mul_a;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= cmd.rom_en;
			vld_s2 <= vld_s1;
		end
	end

	always_comb begin
		if (term_s1 == TERM_CA || term_s1 == TERM_SA) mul_a = n_q;
		else mul_a = {{(N_W - RAD_W){1'b0}}, pen_distance};
	end

	always_ff @(posedge clk) begin
		term_s1 <= cmd.rom_term;
		term_s2 <= term_s1;
		prod_s2 <= mul_a * sine_s1;
	end

	// accumulate the four terms
	logic signed [ACC_W-1:0] prod_ext;
	assign prod_ext = {prod_s2[PROD_W-1], prod_s2};
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			acc_x_q <= '0;
			acc_y_q <= '0;
		end else if (vld_s2) begin
			case (term_s2)
				TERM_CA: acc_x_q <= acc_x_q + prod_ext;
				TERM_SA: acc_y_q <= acc_y_q + prod_ext;
				TERM_CB: acc_x_q <= curve_mode ? acc_x_q + prod_ext : acc_x_q - prod_ext;
				default: acc_y_q <= acc_y_q - prod_ext;
			endcase
		end
	end

	// divider: |n| * step / r, six quotient bits a cycle
	logic [N_W-2:0] n_mag;
	logic [DIV_W-1:0] mag, quo_d;
	logic [RAD_W-1:0] rem_d;
	always_comb begin
		logic [RAD_W:0] t;
		n_mag = n_q[N_W-1] ? (N_W - 1)'(-n_q) : n_q[N_W-2:0];
		mag = DIV_W'(n_mag) * DIV_W'(phase_step);
		quo_d = quo_q;
		rem_d = rem_q;
		for (int i = 0; i < int'(DIV_DIGIT); i++) begin
			t = {rem_d, quo_d[DIV_W-1]};
			quo_d = {quo_d[DIV_W-2:0], 1'b0};
			if (t >= {1'b0, small_radius}) begin
				t = t - {1'b0, small_radius};
				quo_d[0] = 1'b1;
			end
			rem_d = t[RAD_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.div_load) begin
			quo_q <= mag;
			rem_q <= '0;
		end else if (cmd.div_en) begin
			quo_q <= quo_d;
			rem_q <= rem_d;
		end
	end

	// advance the phases at the end of the item if its step_enable was set
	logic [PHASE_W-1:0] inc;
	logic degen;
	assign degen = small_radius == '0;
	assign inc = n_q[N_W-1] ? -quo_q[PHASE_W-1:0] : quo_q[PHASE_W-1:0];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			primary_q <= '0;
			secondary_q <= '0;
		end else if (cmd.finish && step_en_q) begin
			primary_q <= primary_q + {1'b0, phase_step};
			if (!degen) secondary_q <= secondary_q + inc;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (cmd.finish) out_valid_q <= 1'b1;
		else if (!out_stall) out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			x_position <= to_coord(acc_x_q);
			y_position <= to_coord(acc_y_q);
			degenerate <= degen;
		end
	end

	assign out_valid = out_valid_q;
	assign status.out_blocked = out_valid_q && out_stall;

	`TPG_ASSERT(a_phase_hold, clk, arst_n, cmd.finish && !step_en_q |=> $stable(primary_q) && $stable(secondary_q))
	`TPG_ASSERT(a_out_loaded, clk, arst_n, cmd.finish |=> out_valid_q)
	`TPG_NEVER(a_no_overwrite, clk, arst_n, cmd.finish && out_valid_q && out_stall)
endmodule
`default_nettype wire

>>> hw/rtl/trochoid_point_generator.sv
// Trochoid point generator: one epitrochoid or hypotrochoid point per item.
// An accepted item runs the radix-64 divide (load plus eight digits), then the finish step
// loads the output register; the next item is accepted only back in idle.
// A stalled output holds the finish step, so no later item is accepted until it drains.
// Reset (arst_n low) clears the phases, the sequencer and the registers to defaults.
// Depends on tpg_pkg, tpg_ctrl, tpg_datapath and tpg_sine_rom.
`default_nettype none
module trochoid_point_generator
	import tpg_pkg::*;
#(
	parameter int unsigned SINE_TABLE_DEPTH = 1024,
	parameter int unsigned SINE_BITS = 16
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 psel,
	input  wire logic                 penable,
	input  wire logic                 pwrite,
	input  wire logic [4:0]           paddr,
	input  wire logic [31:0]          pwdata,
	output logic [31:0]               prdata,
	output logic                      pready,
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire logic                 step_enable,
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output logic signed [COORD_W-1:0] x_position,
	output logic signed [COORD_W-1:0] y_position,
	output logic                      degenerate
);
	logic curve_mode_q;
	logic [RAD_W-1:0] big_radius_q, small_radius_q, pen_distance_q;
	logic [STEP_W-1:0] phase_step_q;
	reg_idx_t reg_idx;
	logic wr_en;
	tpg_cmd_t cmd;
	tpg_status_t status;

	assign pready = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[4:2]);
	assign wr_en = psel && penable && pwrite && pready;

	// write the configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			curve_mode_q <= 1'b0;
			big_radius_q <= 14'd1280;
			small_radius_q <= 14'd768;
			pen_distance_q <= 14'd1280;
			phase_step_q <= 31'd3417807;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_CURVE_MODE:   curve_mode_q <= pwdata[0];
				REG_BIG_RADIUS:   big_radius_q <= pwdata[RAD_W-1:0];
				REG_SMALL_RADIUS: small_radius_q <= pwdata[RAD_W-1:0];
				REG_PEN_DISTANCE: pen_distance_q <= pwdata[RAD_W-1:0];
				REG_PHASE_STEP:   phase_step_q <= pwdata[STEP_W-1:0];
				default: ;
			endcase
		end
	end

	// read back
	always_comb begin
		unique case (reg_idx)
			REG_CURVE_MODE:   prdata = {31'd0, curve_mode_q};
			REG_BIG_RADIUS:   prdata = {18'd0, big_radius_q};
			REG_SMALL_RADIUS: prdata = {18'd0, small_radius_q};
			REG_PEN_DISTANCE: prdata = {18'd0, pen_distance_q};
			REG_PHASE_STEP:   prdata = {1'b0, phase_step_q};
			default:          prdata = '0;
		endcase
	end

	tpg_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.status   (status),
		.cmd      (cmd)
	);

	tpg_datapath #(.SINE_TABLE_DEPTH(SINE_TABLE_DEPTH), .SINE_BITS(SINE_BITS)) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.step_enable  (step_enable),
		.curve_mode   (curve_mode_q),
		.big_radius   (big_radius_q),
		.small_radius (small_radius_q),
		.pen_distance (pen_distance_q),
		.phase_step   (phase_step_q),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.x_position   (x_position),
		.y_position   (y_position),
		.degenerate   (degenerate)
	);
endmodule
`default_nettype wire

>>> tb/tb_top.sv
// Self-checking testbench for the trochoid point generator.
// Depends on tpg_pkg and trochoid_point_generator; drives items and registers, checks points.
`default_nettype none
module tb_top;
	import tpg_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int TABLE_DEPTH = 1024;
	localparam int AMP_BITS = 16;
	localparam longint Q30 = 64'd1073741824;
	localparam longint HALF_PI = 64'd1686629713;
	localparam int RUN_LIMIT = 400000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [4:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	logic in_valid = 1'b0;
	logic in_stall;
	logic step_enable = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [15:0] x_position, y_position;
	logic degenerate;

	typedef struct packed {
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic degen;
	} point_t;

	// predictor copy of registers and phases
	logic mode_hypo;
	logic [13:0] rad_big, rad_small, pen_dist;
	logic [30:0] step_size;
	logic [31:0] phase_a, phase_b;

	logic step_queue[$];
	point_t point_queue[$];
	int errors = 0;
	int cycles = 0;
	bit quiet_send = 1'b0;
	bit quiet_recv = 1'b0;
	bit hold_send = 1'b0;

	trochoid_point_generator dut (.*);

	always #5 clk = ~clk;

	// sine table entry for a phase
	function automatic longint sine_of(logic [31:0] ph);
		longint unsigned q, x, x2, h, s, v;
		logic [31:0] t;
		longint unsigned f;
		q = (longint'(ph) * TABLE_DEPTH) >> 32;
		t = 32'((q << 32) / TABLE_DEPTH);
		f = t[29:0];
		if (t[30]) f = Q30 - f;
		x = (f * HALF_PI) >> 30;
		x2 = (x * x) >> 30;
		h = Q30 - x2 / 110;
		h = Q30 - ((x2 * h) >> 30) / 72;
		h = Q30 - ((x2 * h) >> 30) / 42;
		h = Q30 - ((x2 * h) >> 30) / 20;
		h = Q30 - ((x2 * h) >> 30) / 6;
		s = (x * h) >> 30;
		v = (s * ((64'd1 << (AMP_BITS - 1)) - 1) + (Q30 >> 1)) >> 30;
		return t[31] ? -longint'(v) : longint'(v);
	endfunction

	// round half up to Q8.8 and saturate
	function automatic logic [15:0] round_coord(longint acc);
		longint r;
		r = (acc + (64'sd1 << (AMP_BITS - 2))) >>> (AMP_BITS - 1);
		if (r > longint'(COORD_LIMIT)) r = longint'(COORD_LIMIT);
		if (r < -longint'(COORD_LIMIT)) r = -longint'(COORD_LIMIT);
		return r[15:0];
	endfunction

	// compute one point, then advance the phases if advance is set
	function automatic point_t next_point(logic advance);
		point_t p;
		longint n, d, ca, sa, cb, sb, xa, ya;
		longint unsigned mag, quo;
		logic [31:0] inc;
		n = mode_hypo ? longint'(rad_big) - longint'(rad_small)
			: longint'(rad_big) + longint'(rad_small);
		d = pen_dist;
		ca = sine_of(phase_a + QUARTER_TURN);
		sa = sine_of(phase_a);
		cb = sine_of(phase_b + QUARTER_TURN);
		sb = sine_of(phase_b);
		xa = mode_hypo ? n * ca + d * cb : n * ca - d * cb;
		ya = n * sa - d * sb;
		p.x = round_coord(xa);
		p.y = round_coord(ya);
		p.degen = (rad_small == 0);
		if (advance) begin
			phase_a += step_size;
			if (!p.degen) begin
				mag = longint'(n < 0 ? -n : n) * step_size;
				quo = mag / rad_small;
				inc = quo[31:0];
				if (n < 0) inc = -inc;
				phase_b += inc;
			end
		end
		return p;
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		$display("mismatch %s: got %0d expected %0d", what, got, want);
		errors++;
	endtask

	// register write over the configuration port, mirrored into the predictor
	task automatic write_reg(reg_idx_t idx, logic [31:0] value);
		@(posedge clk);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
		paddr <= 5'(4 * idx); pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		case (idx)
			REG_CURVE_MODE: mode_hypo = value[0];
			REG_BIG_RADIUS: rad_big = value[13:0];
			REG_SMALL_RADIUS: rad_small = value[13:0];
			REG_PEN_DISTANCE: pen_dist = value[13:0];
			REG_PHASE_STEP: step_size = value[30:0];
			default: ;
		endcase
	endtask

	// wait for the block to drain before touching the registers
	task automatic wait_drained();
		while (step_queue.size() != 0 || point_queue.size() != 0 || in_valid)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic set_curve(logic hypo, int big, int sml, int pen, logic [31:0] stp);
		wait_drained();
		write_reg(REG_CURVE_MODE, hypo);
		write_reg(REG_BIG_RADIUS, big);
		write_reg(REG_SMALL_RADIUS, sml);
		write_reg(REG_PEN_DISTANCE, pen);
		write_reg(REG_PHASE_STEP, stp);
	endtask

	// driver: present queued items, hold while stalled
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (!in_valid || !in_stall) begin
			if (step_queue.size() != 0 && !hold_send
					&& (quiet_send || $urandom_range(99) >= 17)) begin
				in_valid <= 1'b1;
				step_enable <= step_queue.pop_front();
			end else begin
				in_valid <= 1'b0;
			end
		end
		// predict when an item is taken
		if (in_valid && !in_stall)
			point_queue.push_back(next_point(step_enable));
		out_stall <= quiet_recv ? 1'b0 : ($urandom_range(99) < 17);
	end

	// monitor: compare each point with the oldest expectation
	always @(posedge clk) begin
		point_t want;
		if (out_valid && !out_stall) begin
			if (point_queue.size() == 0) begin
				report_mismatch("unexpected point", x_position, 0);
			end else begin
				want = point_queue.pop_front();
				if (x_position !== want.x) report_mismatch("x_position", x_position, want.x);
				if (y_position !== want.y) report_mismatch("y_position", y_position, want.y);
				if (degenerate !== want.degen)
					report_mismatch("degenerate", degenerate, want.degen);
			end
		end
		if (cycles > RUN_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	task automatic push_random(int count);
		repeat (count) step_queue.push_back($urandom_range(99) < 85);
	endtask

	initial begin
		mode_hypo = 1'b0; rad_big = 14'd1280; rad_small = 14'd768;
		pen_dist = 14'd1280; step_size = 31'd3417807;
		phase_a = '0; phase_b = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		// directed: reset settings, hold and advance
		step_queue.push_back(1'b0);
		repeat (4) step_queue.push_back(1'b1);
		step_queue.push_back(1'b0);
		// zero small radius holds the second term
		set_curve(1'b0, 1280, 0, 1280, 32'h0100_0000);
		repeat (3) step_queue.push_back(1'b1);
		// hypotrochoid with R < r turns backwards
		set_curve(1'b1, 512, 2048, 10240, 32'h0200_0000);
		repeat (3) step_queue.push_back(1'b1);
		// extremes: saturation and the largest step
		set_curve(1'b0, 16383, 16383, 16383, 32'h7FFF_FFFF);
		repeat (3) step_queue.push_back(1'b1);
		set_curve(1'b1, 10240, 1, 0, 32'h0000_0001);
		repeat (3) step_queue.push_back(1'b1);
		set_curve(1'b1, 0, 10240, 10240, 32'hFFFF_FFFF);
		repeat (3) step_queue.push_back(1'b1);
		// once drained, hold the sender with an item queued for a while, then release it
		wait_drained();
		hold_send = 1'b1;
		step_queue.push_back(1'b1);
		repeat (30) @(posedge clk);
		hold_send = 1'b0;
		// random phases with random settings
		for (int ph = 0; ph < 14; ph++) begin
			if (ph % 3 == 0)
				set_curve($urandom_range(1), $urandom_range(10240),
					$urandom_range(10240), $urandom_range(10240), $urandom);
			else
				set_curve($urandom_range(1), $urandom_range(16383),
					($urandom_range(9) == 0) ? 0 : $urandom_range(16383),
					$urandom_range(16383), $urandom);
			quiet_send = (ph == 5);
			quiet_recv = (ph == 5);
			push_random(100);
		end
		wait_drained();
		quiet_send = 1'b0;
		quiet_recv = 1'b0;
		repeat (40) @(posedge clk);
		if (errors == 0 && point_queue.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end
endmodule
`default_nettype wire

>>> files.f
+incdir+hw/rtl
hw/rtl/tpg_pkg.sv
hw/rtl/tpg_sine_rom.sv
hw/rtl/tpg_ctrl.sv
hw/rtl/tpg_datapath.sv
hw/rtl/trochoid_point_generator.sv
tb/tb_top.sv
